>>> design/rolling_historical_volatility_macros.svh
// ----------------------------------------------------------------------------
// rolling historical volatility assertion macros
// shared property wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ROLLING_HISTORICAL_VOLATILITY_MACROS_SVH
`define ROLLING_HISTORICAL_VOLATILITY_MACROS_SVH

`ifndef ASSERT_OFF

// plain property checked on every rising clock edge outside reset
`define RHV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rhv assertion failed");

// same-cycle implication
`define RHV_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rhv implication failed");

// next-cycle implication
`define RHV_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rhv next-cycle implication failed");

`else

`define RHV_ASSERT(lbl, prop)
`define RHV_ASSERT_IMP(lbl, pre, post)
`define RHV_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

>>> design/rhv_pkg.sv
// ----------------------------------------------------------------------------
// rhv_pkg
// widths, constants and shared types of the rolling volatility block
// ----------------------------------------------------------------------------
package rhv_pkg;

    // request kinds carried in tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // return window
    localparam int WINDOW      = 64;
    localparam int IDX_W       = $clog2(WINDOW);
    localparam int CNT_W       = $clog2(WINDOW + 1);
    localparam int MIN_RETURNS = 5;

    // field widths
    localparam int SPOT_W = 32;
    localparam int RET_W  = 24;
    localparam int HV_W   = 32;

    // log2 format: 5 integer bits, 28 fraction bits
    localparam int FRAC_W = 28;
    localparam int EXP_W  = 5;
    localparam int LOG_W  = EXP_W + FRAC_W;

    // running totals
    localparam int S1_W = RET_W + IDX_W + 1;
    localparam int S2_W = 2 * RET_W + IDX_W;
    localparam int SQ_W = 2 * RET_W - 1;
    localparam int D_W  = 59;

    // divide and root unit
    localparam int NUM_W  = 75;
    localparam int DEN_W  = 12;
    localparam int ROOT_W = 38;

    // ln2 in Q30 and 252 * 256 annualising scale
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [15:0] ANN_SCALE = 16'd64512;

    // saturation limits of the Q4.20 return
    localparam logic [RET_W-1:0] RET_POS_MAX = 24'h7FFFFF;
    localparam logic [RET_W-1:0] RET_NEG_MAG = 24'h800000;

    // request into the divide and root unit
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } ds_req_t;

    // status back from the divide and root unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } ds_rsp_t;

endpackage

>>> design/rhv_mul.sv
// ----------------------------------------------------------------------------
// rhv_mul
// shared 32 x 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module rhv_mul
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    // one multiply per cycle, result registered
    always_ff @(posedge clk)
    begin
        product_reg <= 64'(a) * 64'(b);
    end

    assign product = product_reg;

endmodule

>>> design/rhv_ring.sv
// ----------------------------------------------------------------------------
// rhv_ring
// ring store of the last returns, one write and one registered read port
// ----------------------------------------------------------------------------
module rhv_ring
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [rhv_pkg::IDX_W-1:0]  wr_addr,
    input  logic [rhv_pkg::RET_W-1:0]  wr_data,
    input  logic [rhv_pkg::IDX_W-1:0]  rd_addr,
    output logic [rhv_pkg::RET_W-1:0]  rd_data
);

    logic [rhv_pkg::RET_W-1:0] mem [rhv_pkg::WINDOW];
    logic [rhv_pkg::RET_W-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/rhv_divsqrt.sv
// ----------------------------------------------------------------------------
// rhv_divsqrt
// bit-serial divide by a small divisor followed by a digit-by-digit root
// ----------------------------------------------------------------------------
module rhv_divsqrt
(
    input  logic             clk,
    input  logic             rst_n,
    input  rhv_pkg::ds_req_t req,
    output rhv_pkg::ds_rsp_t rsp
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    localparam int CNT_W    = $clog2(rhv_pkg::NUM_W + 1);
    localparam int X_W      = rhv_pkg::NUM_W + 1;
    localparam int REM_W    = rhv_pkg::ROOT_W + 2;
    localparam int TRY_W    = REM_W + 2;
    localparam int DREM_W   = rhv_pkg::DEN_W + 1;

    logic [1:0]                  phase_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [X_W-1:0]              x_reg;
    logic [REM_W-1:0]            rem_reg;
    logic [rhv_pkg::DEN_W-1:0]   den_reg;
    logic [rhv_pkg::ROOT_W-1:0]  root_reg;
    logic                        done_reg;

    logic [DREM_W-1:0]           div_try;
    logic                        div_ge;
    logic [TRY_W-1:0]            sq_try;
    logic [TRY_W-1:0]            sq_sub;
    logic                        sq_ge;

    // restoring divide step: one quotient bit
    always_comb
    begin
        div_try = {rem_reg[rhv_pkg::DEN_W-1:0], x_reg[rhv_pkg::NUM_W-1]};
        div_ge  = div_try >= {1'b0, den_reg};
    end

    // root step: two radicand bits in, one root bit out
    always_comb
    begin
        sq_try = {rem_reg, x_reg[X_W-1:X_W-2]};
        sq_sub = {2'b00, root_reg, 2'b01};
        sq_ge  = sq_try >= sq_sub;
    end

    // sequencing of both phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            x_reg     <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            root_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        x_reg     <= {1'b0, req.num};
                        den_reg   <= req.den;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= PH_DIV;
                    end
                end
                PH_DIV:
                begin
                    x_reg <= {1'b0, x_reg[rhv_pkg::NUM_W-2:0], div_ge};
                    if (cnt_reg == CNT_W'(rhv_pkg::NUM_W - 1))
                    begin
                        // quotient now sits in x_reg; remainder and root restart at zero
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= PH_SQRT;
                    end
                    else
                    begin
                        if (div_ge)
                        begin
                            rem_reg <= REM_W'(div_try - {1'b0, den_reg});
                        end
                        else
                        begin
                            rem_reg <= REM_W'(div_try);
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                PH_SQRT:
                begin
                    if (sq_ge)
                    begin
                        rem_reg  <= REM_W'(sq_try - sq_sub);
                    end
                    else
                    begin
                        rem_reg  <= REM_W'(sq_try);
                    end
                    root_reg <= {root_reg[rhv_pkg::ROOT_W-2:0], sq_ge};
                    x_reg    <= {x_reg[X_W-3:0], 2'b00};
                    if (cnt_reg == CNT_W'(rhv_pkg::ROOT_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= PH_IDLE;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    assign rsp.busy = phase_reg != PH_IDLE;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

>>> design/rolling_historical_volatility.sv
// Steps per nonzero spot tick: accept, 5 normalise steps, 29 log2 squaring steps on the
// shared multiplier, output; a tick that adds a return also runs the ratio and update
// states, and with five or more held a 75-step divide and a 38-step root.
// A clear request or zero spot skips to the output step; a full output register stalls the
// output step. One request is in work at a time; the next is taken after the output step.
// Reset is asynchronous, active low, and empties the window and all totals.
// ----------------------------------------------------------------------------
// rolling_historical_volatility
// rolling close-to-close log-return volatility, annualised, in fixed point
// ----------------------------------------------------------------------------
`include "rolling_historical_volatility_macros.svh"

module rolling_historical_volatility
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] spot
    input  logic [0:0]  s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] hv, [55:32] log_return, [62:56] return_count
    output logic [1:0]  m_tuser    // [0] hv_ready, [1] return_taken
);

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_NORM = 5'd1;
    localparam logic [4:0] ST_LOG  = 5'd2;
    localparam logic [4:0] ST_RAT1 = 5'd3;
    localparam logic [4:0] ST_RAT2 = 5'd4;
    localparam logic [4:0] ST_RAT3 = 5'd5;
    localparam logic [4:0] ST_UPD1 = 5'd6;
    localparam logic [4:0] ST_UPD2 = 5'd7;
    localparam logic [4:0] ST_UPD3 = 5'd8;
    localparam logic [4:0] ST_V1   = 5'd9;
    localparam logic [4:0] ST_V2   = 5'd10;
    localparam logic [4:0] ST_V3   = 5'd11;
    localparam logic [4:0] ST_V4   = 5'd12;
    localparam logic [4:0] ST_V5   = 5'd13;
    localparam logic [4:0] ST_V6   = 5'd14;
    localparam logic [4:0] ST_V7   = 5'd15;
    localparam logic [4:0] ST_V8   = 5'd16;
    localparam logic [4:0] ST_ROOT = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    localparam int RET_W = rhv_pkg::RET_W;
    localparam int S1_W  = rhv_pkg::S1_W;
    localparam int S2_W  = rhv_pkg::S2_W;
    localparam int SQ_W  = rhv_pkg::SQ_W;
    localparam int D_W   = rhv_pkg::D_W;
    localparam int CNT_W = rhv_pkg::CNT_W;
    localparam int IDX_W = rhv_pkg::IDX_W;
    localparam int LOG_W = rhv_pkg::LOG_W;
    localparam int FRAC_W = rhv_pkg::FRAC_W;
    localparam int EXP_W = rhv_pkg::EXP_W;

    logic [4:0]                 state_reg;
    logic [4:0]                 step_reg;
    logic [31:0]                spot_reg;
    logic                       take_reg;
    logic                       clr_reg;
    logic [31:0]                x_reg;
    logic [EXP_W-1:0]           e_reg;
    logic [FRAC_W-1:0]          f_reg;
    logic [LOG_W-1:0]           cur_log_reg;
    logic [LOG_W-1:0]           prev_log_reg;
    logic [31:0]                prev_spot_reg;
    logic                       have_prev_reg;
    logic [LOG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic [RET_W-1:0]           r_reg;
    logic [RET_W-1:0]           rmag_reg;
    logic [SQ_W-1:0]            sq_new_reg;
    logic [S1_W-1:0]            s1_reg;
    logic [S2_W-1:0]            s2_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [IDX_W-1:0]           wi_reg;
    logic [D_W-1:0]             a_reg;
    logic [D_W-1:0]             d_reg;
    logic [47:0]                t_reg;
    logic [rhv_pkg::NUM_W-1:0]  num_reg;
    logic [rhv_pkg::HV_W-1:0]   hv_reg;
    logic                       m_tvalid_reg;
    logic [63:0]                m_tdata_reg;
    logic [1:0]                 m_tuser_reg;

    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [63:0]                product;
    logic [31:0]                fold;
    logic [RET_W-1:0]           old_ret;
    logic [RET_W-1:0]           old_mag;
    logic [S1_W-1:0]            s1_mag;
    logic [63:0]                rat_sum;
    logic [25:0]                rat_q;
    logic                       full;
    logic [CNT_W-1:0]           n_next;
    logic [S1_W-1:0]            s1_next;
    logic [S2_W-1:0]            s2_next;
    logic                       ring_wr;
    logic                       accept;
    logic                       out_free;
    rhv_pkg::ds_req_t           ds_req;
    rhv_pkg::ds_rsp_t           ds_rsp;

    // shared multiplier
    rhv_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // return window store
    rhv_ring u_ring
    (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (wi_reg),
        .wr_data (r_reg),
        .rd_addr (wi_reg),
        .rd_data (old_ret)
    );

    // divide by n(n-1) and square root
    rhv_divsqrt u_divsqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ds_req),
        .rsp   (ds_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign ds_req.start = state_reg == ST_V8;
    assign ds_req.num   = num_reg;
    assign ds_req.den   = product[rhv_pkg::DEN_W-1:0];

    // squaring fold: renormalise the truncated square
    assign fold = product[63] ? product[63:32] : product[62:31];

    // magnitudes of the oldest return and the running sum
    always_comb
    begin
        old_mag = old_ret[RET_W-1] ? RET_W'(~old_ret + 1'b1) : old_ret;
        s1_mag  = s1_reg[S1_W-1] ? S1_W'(~s1_reg + 1'b1) : s1_reg;
    end

    // rounding of the scaled log difference
    always_comb
    begin
        rat_sum = product + (mag_reg[LOG_W-1] ? {rhv_pkg::LN2_Q30, 32'd0} : 64'd0)
                  + 64'h0000_0020_0000_0000;
        rat_q   = rat_sum[63:38];
    end

    // window and total update
    always_comb
    begin
        full    = n_reg >= CNT_W'(rhv_pkg::WINDOW);
        n_next  = full ? n_reg : CNT_W'(n_reg + 1'b1);
        s1_next = S1_W'(s1_reg + {{(S1_W-RET_W){r_reg[RET_W-1]}}, r_reg}
                  - (full ? {{(S1_W-RET_W){old_ret[RET_W-1]}}, old_ret} : '0));
        s2_next = S2_W'(s2_reg + S2_W'(sq_new_reg)
                  - (full ? S2_W'(product[SQ_W-1:0]) : '0));
        ring_wr = state_reg == ST_UPD3;
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOG:
            begin
                mul_a = (step_reg == '0) ? x_reg : fold;
                mul_b = mul_a;
            end
            ST_RAT2:
            begin
                mul_a = mag_reg[31:0];
                mul_b = rhv_pkg::LN2_Q30;
            end
            ST_UPD1:
            begin
                mul_a = 32'(rmag_reg);
                mul_b = 32'(rmag_reg);
            end
            ST_UPD2:
            begin
                mul_a = 32'(old_mag);
                mul_b = 32'(old_mag);
            end
            ST_V1:
            begin
                mul_a = 32'(n_reg);
                mul_b = s2_reg[31:0];
            end
            ST_V2:
            begin
                mul_a = 32'(n_reg);
                mul_b = 32'(s2_reg[S2_W-1:32]);
            end
            ST_V3:
            begin
                mul_a = 32'(s1_mag);
                mul_b = 32'(s1_mag);
            end
            ST_V5:
            begin
                mul_a = d_reg[31:0];
                mul_b = 32'(rhv_pkg::ANN_SCALE);
            end
            ST_V6:
            begin
                mul_a = 32'(d_reg[D_W-1:32]);
                mul_b = 32'(rhv_pkg::ANN_SCALE);
            end
            ST_V7:
            begin
                mul_a = 32'(n_reg);
                mul_b = 32'(n_reg - 1'b1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // result valid: set when a result is loaded, cleared once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_FIN && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            spot_reg      <= '0;
            take_reg      <= 1'b0;
            clr_reg       <= 1'b0;
            x_reg         <= '0;
            e_reg         <= '0;
            f_reg         <= '0;
            cur_log_reg   <= '0;
            prev_log_reg  <= '0;
            prev_spot_reg <= '0;
            have_prev_reg <= 1'b0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            r_reg         <= '0;
            rmag_reg      <= '0;
            sq_new_reg    <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            n_reg         <= '0;
            wi_reg        <= '0;
            a_reg         <= '0;
            d_reg         <= '0;
            t_reg         <= '0;
            num_reg       <= '0;
            hv_reg        <= '0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        spot_reg <= s_tdata;
                        r_reg    <= '0;
                        if (s_tuser[0] == rhv_pkg::CMD_CLEAR)
                        begin
                            // clear request empties history
                            s1_reg    <= '0;
                            s2_reg    <= '0;
                            n_reg     <= '0;
                            wi_reg    <= '0;
                            hv_reg    <= '0;
                            take_reg  <= 1'b0;
                            clr_reg   <= 1'b1;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            clr_reg  <= 1'b0;
                            take_reg <= have_prev_reg && (prev_spot_reg != '0)
                                        && (s_tdata != '0);
                            if (s_tdata != '0)
                            begin
                                x_reg     <= s_tdata;
                                e_reg     <= EXP_W'(31);
                                step_reg  <= '0;
                                state_reg <= ST_NORM;
                            end
                            else
                            begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_NORM:
                begin
                    // binary search for the leading one
                    case (step_reg)
                        5'd0:
                        begin
                            if (x_reg[31:16] == '0)
                            begin
                                x_reg <= {x_reg[15:0], 16'd0};
                                e_reg <= e_reg - EXP_W'(16);
                            end
                        end
                        5'd1:
                        begin
                            if (x_reg[31:24] == '0)
                            begin
                                x_reg <= {x_reg[23:0], 8'd0};
                                e_reg <= e_reg - EXP_W'(8);
                            end
                        end
                        5'd2:
                        begin
                            if (x_reg[31:28] == '0)
                            begin
                                x_reg <= {x_reg[27:0], 4'd0};
                                e_reg <= e_reg - EXP_W'(4);
                            end
                        end
                        5'd3:
                        begin
                            if (x_reg[31:30] == '0)
                            begin
                                x_reg <= {x_reg[29:0], 2'd0};
                                e_reg <= e_reg - EXP_W'(2);
                            end
                        end
                        default:
                        begin
                            if (!x_reg[31])
                            begin
                                x_reg <= {x_reg[30:0], 1'b0};
                                e_reg <= e_reg - EXP_W'(1);
                            end
                        end
                    endcase
                    if (step_reg == 5'd4)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_LOG;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_LOG:
                begin
                    // one fraction bit per squaring
                    if (step_reg != '0)
                    begin
                        f_reg <= {f_reg[FRAC_W-2:0], product[63]};
                    end
                    if (step_reg == 5'(FRAC_W))
                    begin
                        cur_log_reg <= {e_reg, f_reg[FRAC_W-2:0], product[63]};
                        state_reg   <= take_reg ? ST_RAT1 : ST_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_RAT1:
                begin
                    neg_reg <= cur_log_reg < prev_log_reg;
                    mag_reg <= (cur_log_reg < prev_log_reg) ? prev_log_reg - cur_log_reg
                                                            : cur_log_reg - prev_log_reg;
                    state_reg <= ST_RAT2;
                end
                ST_RAT2:
                begin
                    state_reg <= ST_RAT3;
                end
                ST_RAT3:
                begin
                    // round, sign and saturate to Q4.20
                    if (!neg_reg)
                    begin
                        if (rat_q > 26'(rhv_pkg::RET_POS_MAX))
                        begin
                            rmag_reg <= rhv_pkg::RET_POS_MAX;
                            r_reg    <= rhv_pkg::RET_POS_MAX;
                        end
                        else
                        begin
                            rmag_reg <= rat_q[RET_W-1:0];
                            r_reg    <= rat_q[RET_W-1:0];
                        end
                    end
                    else
                    begin
                        if (rat_q >= 26'(rhv_pkg::RET_NEG_MAG))
                        begin
                            rmag_reg <= rhv_pkg::RET_NEG_MAG;
                            r_reg    <= rhv_pkg::RET_NEG_MAG;
                        end
                        else
                        begin
                            rmag_reg <= rat_q[RET_W-1:0];
                            r_reg    <= RET_W'(~rat_q[RET_W-1:0] + 1'b1);
                        end
                    end
                    state_reg <= ST_UPD1;
                end
                ST_UPD1:
                begin
                    state_reg <= ST_UPD2;
                end
                ST_UPD2:
                begin
                    sq_new_reg <= product[SQ_W-1:0];
                    state_reg  <= ST_UPD3;
                end
                ST_UPD3:
                begin
                    s1_reg <= s1_next;
                    s2_reg <= s2_next;
                    n_reg  <= n_next;
                    wi_reg <= (wi_reg == IDX_W'(rhv_pkg::WINDOW - 1)) ? '0
                                                                      : wi_reg + 1'b1;
                    if (n_next >= CNT_W'(rhv_pkg::MIN_RETURNS))
                    begin
                        state_reg <= ST_V1;
                    end
                    else
                    begin
                        hv_reg    <= '0;
                        state_reg <= ST_FIN;
                    end
                end
                ST_V1:
                begin
                    state_reg <= ST_V2;
                end
                ST_V2:
                begin
                    a_reg     <= D_W'(product[38:0]);
                    state_reg <= ST_V3;
                end
                ST_V3:
                begin
                    a_reg     <= D_W'(a_reg + {product[D_W-33:0], 32'd0});
                    state_reg <= ST_V4;
                end
                ST_V4:
                begin
                    d_reg     <= D_W'(a_reg - product[D_W-1:0]);
                    state_reg <= ST_V5;
                end
                ST_V5:
                begin
                    state_reg <= ST_V6;
                end
                ST_V6:
                begin
                    t_reg     <= product[47:0];
                    state_reg <= ST_V7;
                end
                ST_V7:
                begin
                    num_reg   <= rhv_pkg::NUM_W'(t_reg)
                                 + {product[rhv_pkg::NUM_W-33:0], 32'd0};
                    state_reg <= ST_V8;
                end
                ST_V8:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (ds_rsp.done)
                    begin
                        hv_reg <= (ds_rsp.root[rhv_pkg::ROOT_W-1:32] != '0)
                                  ? '1 : ds_rsp.root[31:0];
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= {1'b0, n_reg, take_reg ? r_reg : '0, hv_reg};
                        m_tuser_reg  <= {take_reg,
                                         n_reg >= CNT_W'(rhv_pkg::MIN_RETURNS)};
                        if (clr_reg)
                        begin
                            prev_spot_reg <= '0;
                            have_prev_reg <= 1'b0;
                        end
                        else
                        begin
                            prev_spot_reg <= spot_reg;
                            prev_log_reg  <= cur_log_reg;
                            have_prev_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // checks on the sequencer and results
    `RHV_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `RHV_ASSERT(a_count_bound, n_reg <= CNT_W'(rhv_pkg::WINDOW))
    `RHV_ASSERT_IMP(a_hv_needs_five, m_tvalid && (m_tdata[31:0] != '0), m_tuser[0])
    `RHV_ASSERT_IMP(a_root_in_phase, ds_rsp.done, state_reg == ST_ROOT)
    `RHV_ASSERT_IMP(a_taken_counts, m_tvalid && m_tuser[1], m_tdata[62:56] != '0)

endmodule

>>> tb/rhv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhv_checker
// watches both streams of the volatility block, predicts each result from
// the accepted requests and compares it field by field
// ----------------------------------------------------------------------------
module rhv_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [31:0] hv;
        logic        hv_ready;
        logic        return_taken;
        logic [23:0] log_return;
        logic [6:0]  return_count;
    } vol_result_t;

    vol_result_t expected_results[$];

    // predictor state
    logic signed [23:0] ring[rhv_pkg::WINDOW];
    int                 ring_wr;
    int                 held;
    logic [31:0]        prev_tick_spot;
    logic               seen_spot;
    longint             sum_ret;
    longint unsigned    sum_sq;

    // log2 in Q28 by repeated squaring of the normalised mantissa
    function automatic logic [63:0] log2_fixed(input logic [31:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] f;
        e = 31;
        f = 0;
        while (e > 0 && !x[e]) e--;
        m = 64'(x) << (31 - e);
        for (int i = rhv_pkg::FRAC_W - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                m = m >> 1;
                f[i] = 1'b1;
            end
        end
        return (64'(e) << rhv_pkg::FRAC_W) | f;
    endfunction

    function automatic logic signed [23:0] ln_ratio(input logic [31:0] cur,
                                                     input logic [31:0] prev);
        logic [63:0] lc;
        logic [63:0] lp;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        lc  = log2_fixed(cur);
        lp  = log2_fixed(prev);
        neg = lc < lp;
        mag = neg ? lp - lc : lc - lp;
        q   = (mag * 64'(rhv_pkg::LN2_Q30) + (64'd1 << 37)) >> 38;
        if (!neg) return (q > 64'h7FFFFF) ? 24'sh7FFFFF : 24'(q);
        if (q >= 64'h800000) return 24'sh800000;
        return 24'(-q);
    endfunction

    // sample deviation of the window, annualised, in Q8.24
    function automatic logic [31:0] annual_vol();
        logic [127:0] s1mag;
        logic [127:0] d;
        logic [127:0] v;
        logic [127:0] r;
        logic [127:0] c;
        if (held < rhv_pkg::MIN_RETURNS) return 0;
        s1mag = (sum_ret < 0) ? 128'(-sum_ret) : 128'(sum_ret);
        d = 128'(held) * 128'(sum_sq) - s1mag * s1mag;
        v = (d * 128'(rhv_pkg::ANN_SCALE)) / 128'(held * (held - 1));
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= v) r = c;
        end
        return (r > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    task automatic empty_history();
        ring_wr        = 0;
        held           = 0;
        prev_tick_spot = 0;
        seen_spot      = 0;
        sum_ret        = 0;
        sum_sq         = 0;
    endtask

    task automatic predict_tick(input logic cmd, input logic [31:0] spot);
        vol_result_t        res;
        logic signed [23:0] r;
        r   = 0;
        res = '{default: 0};
        if (cmd == rhv_pkg::CMD_CLEAR) begin
            empty_history();
        end
        else begin
            if (seen_spot && prev_tick_spot != 0 && spot != 0) begin
                r = ln_ratio(spot, prev_tick_spot);
                res.return_taken = 1'b1;
                if (held >= rhv_pkg::WINDOW) begin
                    sum_ret -= longint'(ring[ring_wr]);
                    sum_sq  -= longint'(ring[ring_wr]) * longint'(ring[ring_wr]);
                end
                else held++;
                ring[ring_wr] = r;
                sum_ret += longint'(r);
                sum_sq  += longint'(r) * longint'(r);
                ring_wr = (ring_wr + 1) % rhv_pkg::WINDOW;
            end
            prev_tick_spot = spot;
            seen_spot = 1'b1;
            res.hv           = annual_vol();
            res.hv_ready     = held >= rhv_pkg::MIN_RETURNS;
            res.log_return   = r;
            res.return_count = 7'(held);
        end
        expected_results.insert(expected_results.size(), res);
    endtask

    assign pending = expected_results.size();

    // watch both streams
    always @(posedge clk)
    begin
        vol_result_t want;
        if (!rst_n) begin
            fail_count = 0;
            empty_history();
            expected_results.delete();
        end
        else begin
            if (s_tvalid && s_tready)
                predict_tick(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end
                else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_tdata[31:0] !== want.hv) begin
                        $error("hv: expected %h actual %h", want.hv, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[55:32] !== want.log_return) begin
                        $error("log_return: expected %h actual %h",
                               want.log_return, m_tdata[55:32]);
                        fail_count++;
                    end
                    if (m_tdata[62:56] !== want.return_count) begin
                        $error("return_count: expected %0d actual %0d",
                               want.return_count, m_tdata[62:56]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.hv_ready) begin
                        $error("hv_ready: expected %b actual %b",
                               want.hv_ready, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.return_taken) begin
                        $error("return_taken: expected %b actual %b",
                               want.return_taken, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives spot ticks and clear requests into the volatility block under
// several idling phases; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;

    localparam int   CYCLE_LIMIT = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          cycles = 0;
    logic [31:0] walk_spot;

    rolling_historical_volatility u_top (.*);

    rhv_checker u_checker (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one request, waiting out the handshake; valid stays up for the next call
    task automatic send_request(input logic cmd, input logic [31:0] spot);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= spot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // random spot: mostly a small walk, sometimes anything
    function automatic logic [31:0] next_spot(input logic [31:0] prev);
        int          k;
        logic [31:0] step;
        k = $urandom_range(99);
        if (k < 4) return 0;
        if (k < 14 || prev == 0) return $urandom;
        step = prev >> $urandom_range(4, 12);
        if ($urandom_range(1)) return prev + step;
        return prev - step;
    endfunction

    initial
    begin
        int phase_items;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = rhv_pkg::CMD_TICK;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first tick, zero spots, extremes, saturation, clear
        send_request(rhv_pkg::CMD_TICK, 32'h0001_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h0000_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h0002_0000);
        send_request(rhv_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_request(rhv_pkg::CMD_TICK, 32'h0000_0001);
        send_request(rhv_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_request(rhv_pkg::CMD_TICK, 32'h0000_0001);
        send_request(rhv_pkg::CMD_TICK, 32'h0000_0001);
        send_request(rhv_pkg::CMD_TICK, 32'h0001_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h0001_8000);
        send_request(rhv_pkg::CMD_TICK, 32'h0001_0000);
        send_request(rhv_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        send_request(rhv_pkg::CMD_TICK, 32'h8000_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h7FFF_FFFF);
        send_request(rhv_pkg::CMD_TICK, 32'h8000_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h8000_0000);
        send_request(rhv_pkg::CMD_TICK, 32'h5555_5555);
        send_request(rhv_pkg::CMD_TICK, 32'hAAAA_AAAA);
        send_request(rhv_pkg::CMD_CLEAR, 32'h0);
        s_tvalid <= 1'b0;

        // pause until everything is back
        drain();

        // random phases
        walk_spot = 32'h0064_0000;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 74; end
                3: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            phase_items = (phase == 4) ? 300 : 400;
            for (int i = 0; i < phase_items; i++) begin
                if ($urandom_range(199) == 0) begin
                    send_request(rhv_pkg::CMD_CLEAR, $urandom);
                end
                else begin
                    walk_spot = next_spot(walk_spot);
                    send_request(rhv_pkg::CMD_TICK, walk_spot);
                end
            end
        end
        s_tvalid <= 1'b0;

        drain();
        repeat (400) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
